// ===== sv/hotr_pkg.sv =====
package hotr_pkg;

  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_W = 15;
  localparam int SAT_W = 7;
  localparam int CH_W = 8;

  localparam int SECTOR_UNITS = 60 << HUE_FRAC_BITS;
  localparam int TURN_UNITS = 6 * SECTOR_UNITS;
  localparam int PCT_FULL = 100;
  localparam int CH_MAX = (1 << CH_W) - 1;

  localparam int HUE_SUM_W = HUE_W + 1;
  localparam int TURN_W = $clog2(TURN_UNITS);
  localparam int SECTOR_W = $clog2(SECTOR_UNITS + 1);
  localparam int NUM_W = $clog2(PCT_FULL * SECTOR_UNITS + 1);

  // The channel denominator PCT_FULL * SECTOR_UNITS equals 375 << DEN_SHIFT.
  localparam int DEN_SHIFT = 4 + HUE_FRAC_BITS;
  localparam int DEN_ODD = 375;
  localparam int WIDE_W = NUM_W + CH_W;
  localparam int SCALED_W = $clog2(CH_MAX * DEN_ODD + 1);
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP = ((1 << RECIP_SHIFT) + DEN_ODD - 1) / DEN_ODD;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W = SCALED_W + RECIP_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    SECT_R_Y = 3'd0,
    SECT_Y_G = 3'd1,
    SECT_G_C = 3'd2,
    SECT_C_B = 3'd3,
    SECT_B_M = 3'd4,
    SECT_M_R = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e             sector;
    logic [SECTOR_W-1:0] frac;
    logic [SAT_W-1:0]    sat;
  } item_t;

endpackage

// ===== sv/hotr_if.sv =====
interface hotr_in_if;
  logic                         valid;
  logic                         ready;
  logic [hotr_pkg::HUE_W-1:0]   base_hue;
  logic [hotr_pkg::HUE_W-1:0]   hue_offset;
  logic [hotr_pkg::SAT_W-1:0]   saturation_pct;

  modport source (output valid, base_hue, hue_offset, saturation_pct, input ready);
  modport sink (input valid, base_hue, hue_offset, saturation_pct, output ready);
endinterface

interface hotr_out_if;
  logic                        valid;
  logic                        ready;
  logic [hotr_pkg::CH_W-1:0]   red;
  logic [hotr_pkg::CH_W-1:0]   green;
  logic [hotr_pkg::CH_W-1:0]   blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== sv/hotr_front.sv =====
module hotr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  hotr_in_if.sink         in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output hotr_pkg::item_t push_item_o
);
  import hotr_pkg::*;

  logic                 s1_valid_q, s2_valid_q;
  logic [TURN_W-1:0]    s1_hue_q;
  logic [SAT_W-1:0]     s1_sat_q;
  item_t                s2_item_q;
  logic                 en1, en2;
  logic [HUE_SUM_W-1:0] sum;
  logic [HUE_SUM_W-1:0] wrapped;
  logic [SAT_W-1:0]     sat_clamped;
  logic [2:0]           sector;
  logic [TURN_W-1:0]    rem;
  logic [SECTOR_W-1:0]  frac;

  assign en2 = !s2_valid_q || push_ready_i;
  assign en1 = !s1_valid_q || en2;
  assign in_i.ready = en1;

  always_comb begin
    sum = HUE_SUM_W'(in_i.base_hue) + HUE_SUM_W'(in_i.hue_offset);
    if (sum >= HUE_SUM_W'(2 * TURN_UNITS)) begin
      wrapped = sum - HUE_SUM_W'(2 * TURN_UNITS);
    end else if (sum >= HUE_SUM_W'(TURN_UNITS)) begin
      wrapped = sum - HUE_SUM_W'(TURN_UNITS);
    end else begin
      wrapped = sum;
    end
    if (in_i.saturation_pct > SAT_W'(PCT_FULL)) begin
      sat_clamped = SAT_W'(PCT_FULL);
    end else begin
      sat_clamped = in_i.saturation_pct;
    end
  end

  always_comb begin
    sector = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (s1_hue_q >= TURN_W'(k * SECTOR_UNITS)) begin
        sector = 3'(k);
      end
    end
    rem = s1_hue_q - TURN_W'(int'(sector) * SECTOR_UNITS);
    if (sector[0]) begin
      frac = SECTOR_W'(SECTOR_UNITS) - rem[SECTOR_W-1:0];
    end else begin
      frac = rem[SECTOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= in_i.valid;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_hue_q <= wrapped[TURN_W-1:0];
      s1_sat_q <= sat_clamped;
    end
    if (en2) begin
      s2_item_q.sector <= sector_e'(sector);
      s2_item_q.frac   <= frac;
      s2_item_q.sat    <= s1_sat_q;
    end
  end

  assign push_valid_o = s2_valid_q;
  assign push_item_o  = s2_item_q;

endmodule

// ===== sv/hotr_queue.sv =====
module hotr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  hotr_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output hotr_pkg::item_t pop_item_o
);
  import hotr_pkg::*;

  item_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;
  logic                   push, pop;

  assign push_ready_o = count_q != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/hotr_back.sv =====
module hotr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  hotr_pkg::item_t pop_item_i,
  hotr_out_if.source      out_o
);
  import hotr_pkg::*;

  logic                en1, en2, en3;
  logic                v1_q, v2_q, v3_q;
  sector_e             sect1_q, sect2_q;
  logic [NUM_W-1:0]    mid_q, low_q;
  logic [PROD_W-1:0]   prod_mid_q, prod_low_q;
  logic [CH_W-1:0]     red_q, green_q, blue_q;
  logic [NUM_W-1:0]    low_num, mid_num;
  logic [WIDE_W-1:0]   wide_mid, wide_low;
  logic [SCALED_W-1:0] y_mid, y_low;
  logic [CH_W-1:0]     ch_mid, ch_low, ch_full;
  logic [CH_W-1:0]     red_d, green_d, blue_d;

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign pop_ready_o = en1;

  always_comb begin
    low_num = NUM_W'(SAT_W'(PCT_FULL) - pop_item_i.sat) * NUM_W'(SECTOR_UNITS);
    mid_num = NUM_W'(pop_item_i.sat) * NUM_W'(pop_item_i.frac) + low_num;
  end

  // Scale by 255, drop the power-of-two part of the denominator, then divide
  // by the odd part with an exact reciprocal multiply.
  always_comb begin
    wide_mid = {mid_q, CH_W'(0)} - WIDE_W'(mid_q);
    wide_low = {low_q, CH_W'(0)} - WIDE_W'(low_q);
    y_mid = wide_mid[DEN_SHIFT +: SCALED_W];
    y_low = wide_low[DEN_SHIFT +: SCALED_W];
  end

  always_comb begin
    ch_mid  = prod_mid_q[RECIP_SHIFT +: CH_W];
    ch_low  = prod_low_q[RECIP_SHIFT +: CH_W];
    ch_full = CH_W'(CH_MAX);
    unique case (sect2_q)
      SECT_R_Y: begin red_d = ch_full; green_d = ch_mid;  blue_d = ch_low;  end
      SECT_Y_G: begin red_d = ch_mid;  green_d = ch_full; blue_d = ch_low;  end
      SECT_G_C: begin red_d = ch_low;  green_d = ch_full; blue_d = ch_mid;  end
      SECT_C_B: begin red_d = ch_low;  green_d = ch_mid;  blue_d = ch_full; end
      SECT_B_M: begin red_d = ch_mid;  green_d = ch_low;  blue_d = ch_full; end
      default:  begin red_d = ch_full; green_d = ch_low;  blue_d = ch_mid;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= pop_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sect1_q <= pop_item_i.sector;
      mid_q   <= mid_num;
      low_q   <= low_num;
    end
    if (en2) begin
      sect2_q    <= sect1_q;
      prod_mid_q <= PROD_W'(y_mid) * PROD_W'(RECIP);
      prod_low_q <= PROD_W'(y_low) * PROD_W'(RECIP);
    end
    if (en3) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_o.valid = v3_q;
  assign out_o.red   = red_q;
  assign out_o.green = green_q;
  assign out_o.blue  = blue_q;

endmodule

// ===== sv/hue_offset_to_rgb_core.sv =====
// Converts a base hue plus a hue offset (1/64-degree units, wrapped modulo one
// full turn) and a saturation percentage (values above 100 act as 100) into
// an 8-bit RGB color at full brightness, each channel exactly
// floor(255 * fraction). The block takes one transaction per clock while
// nothing stalls and gives one result transaction for each, in order. A
// result passes through two front stages (hue wrap, then sector split), the
// four-entry queue, and three back stages (chroma mix, reciprocal multiply,
// channel select). The queue lets the front keep accepting while the output
// side is stalled, until the queue is full.
module hue_offset_to_rgb_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  hotr_in_if.sink    in_i,
  hotr_out_if.source out_o
);
  import hotr_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  hotr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  hotr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  hotr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule
